// ===== rtl/cps_pkg.sv =====
package cps_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int IO_W        = 32;

	localparam int CW      = COORD_WIDTH;
	localparam int DIFF_W  = CW + 1;
	localparam int LEN_W   = 2 * CW;
	localparam int DOT_W   = 2 * CW + 1;
	localparam int T_W     = 31;
	localparam int SHIFT   = T_W - FRAC_BITS;
	localparam int PRD_W   = CW + T_W + 1;
	localparam int SH_W    = PRD_W - FRAC_BITS;
	localparam int SUM_W   = SH_W + 1;

	localparam logic [T_W-1:0] T_MAX = {T_W{1'b1}};
	localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

	localparam int FRONT_STAGES = 4;
	localparam int DIV_STAGES   = T_W;
	localparam int BACK_STAGES  = 3;

	typedef struct packed {
		logic [CW-1:0]    sx;
		logic [CW-1:0]    sy;
		logic [CW-1:0]    dx;
		logic [CW-1:0]    dy;
		logic             seg;
		logic             positive;
		logic             zero;
		logic             ovf;
		logic [LEN_W-1:0] len2;
		logic [LEN_W-1:0] rem;
		logic [T_W-1:0]   low;
		logic [T_W-1:0]   q;
	} div_t;

endpackage

// ===== rtl/cps_front.sv =====
module cps_front import cps_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            v_in,
	input  logic            seg_mode,
	input  logic [IO_W-1:0] point_x,
	input  logic [IO_W-1:0] point_y,
	input  logic [IO_W-1:0] start_x,
	input  logic [IO_W-1:0] start_y,
	input  logic [IO_W-1:0] dir_x,
	input  logic [IO_W-1:0] dir_y,
	output logic            v_out,
	output div_t            d_out
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [DIFF_W-1:0] vx_s1, vy_s1;
	logic [CW-1:0] sx_s1, sy_s1, dx_s1, dy_s1;
	logic seg_s1;

	logic signed [LEN_W-1:0] p1_s2, p2_s2;
	logic [LEN_W-2:0] sq1_s2, sq2_s2;
	logic [CW-1:0] sx_s2, sy_s2, dx_s2, dy_s2;
	logic seg_s2;

	logic signed [DOT_W-1:0] dot_s3;
	logic [LEN_W-1:0] len2_s3;
	logic [CW-1:0] sx_s3, sy_s3, dx_s3, dy_s3;
	logic seg_s3;

	div_t d_s4;

	logic signed [DIFF_W+CW-1:0] m1, m2;
	logic signed [2*CW-1:0] q1, q2;
	logic [LEN_W-1:0] dot_u;

	assign m1 = vx_s1 * $signed(dx_s1);
	assign m2 = vy_s1 * $signed(dy_s1);
	assign q1 = $signed(dx_s1) * $signed(dx_s1);
	assign q2 = $signed(dy_s1) * $signed(dy_s1);
	assign dot_u = dot_s3[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// offset of the query point from the line start
			vx_s1  <= $signed({point_x[CW-1], point_x[CW-1:0]})
				- $signed({start_x[CW-1], start_x[CW-1:0]});
			vy_s1  <= $signed({point_y[CW-1], point_y[CW-1:0]})
				- $signed({start_y[CW-1], start_y[CW-1:0]});
			sx_s1  <= start_x[CW-1:0];
			sy_s1  <= start_y[CW-1:0];
			dx_s1  <= dir_x[CW-1:0];
			dy_s1  <= dir_y[CW-1:0];
			seg_s1 <= seg_mode;

			p1_s2  <= m1[LEN_W-1:0];
			p2_s2  <= m2[LEN_W-1:0];
			sq1_s2 <= q1[LEN_W-2:0];
			sq2_s2 <= q2[LEN_W-2:0];
			sx_s2  <= sx_s1;
			sy_s2  <= sy_s1;
			dx_s2  <= dx_s1;
			dy_s2  <= dy_s1;
			seg_s2 <= seg_s1;

			dot_s3  <= $signed({p1_s2[LEN_W-1], p1_s2}) + $signed({p2_s2[LEN_W-1], p2_s2});
			len2_s3 <= {1'b0, sq1_s2} + {1'b0, sq2_s2};
			sx_s3   <= sx_s2;
			sy_s3   <= sy_s2;
			dx_s3   <= dx_s2;
			dy_s3   <= dy_s2;
			seg_s3  <= seg_s2;

			// seed the divider; flag a quotient that would not fit in t
			d_s4.sx       <= sx_s3;
			d_s4.sy       <= sy_s3;
			d_s4.dx       <= dx_s3;
			d_s4.dy       <= dy_s3;
			d_s4.seg      <= seg_s3;
			d_s4.positive <= !dot_s3[DOT_W-1] && (dot_s3 != '0);
			d_s4.zero     <= (len2_s3 == '0);
			d_s4.ovf      <= {{SHIFT{1'b0}}, dot_u} >= {len2_s3, {SHIFT{1'b0}}};
			d_s4.len2     <= len2_s3;
			d_s4.rem      <= {{SHIFT{1'b0}}, dot_u[LEN_W-1:SHIFT]};
			d_s4.low      <= {dot_u[SHIFT-1:0], {FRAC_BITS{1'b0}}};
			d_s4.q        <= '0;
		end
	end

	assign v_out = v_s4;
	assign d_out = d_s4;

endmodule

// ===== rtl/cps_div_stage.sv =====
module cps_div_stage import cps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  div_t d_in,
	output logic v_out,
	output div_t d_out
);

	logic v_s1;
	div_t d_s1;
	div_t d_c;
	logic [LEN_W:0] trial;
	logic [LEN_W:0] diff;
	logic take;

	assign trial = {d_in.rem, d_in.low[T_W-1]};
	assign diff  = trial - {1'b0, d_in.len2};
	assign take  = trial >= {1'b0, d_in.len2};

	// one restoring step: bring down the next bit, subtract where it fits
	always_comb begin
		d_c     = d_in;
		d_c.rem = take ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
		d_c.low = {d_in.low[T_W-2:0], 1'b0};
		d_c.q   = {d_in.q[T_W-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= d_c;
		end
	end

	assign v_out = v_s1;
	assign d_out = d_s1;

endmodule

// ===== rtl/cps_back.sv =====
module cps_back import cps_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            v_in,
	input  div_t            d_in,
	output logic            v_out,
	output logic [IO_W-1:0] near_x,
	output logic [IO_W-1:0] near_y,
	output logic [T_W-1:0]  param_t,
	output logic            zero_direction
);

	logic v_s1, v_s2, v_s3;
	logic [T_W-1:0] t_s1, t_s2, t_s3;
	logic [CW-1:0] sx_s1, sy_s1, dx_s1, dy_s1, sx_s2, sy_s2;
	logic zero_s1, zero_s2, zero_s3, seg_s1;
	logic signed [PRD_W-1:0] px_s2, py_s2;
	logic [CW-1:0] nx_s3, ny_s3;
	logic [T_W-1:0] t_c;

	function automatic logic [CW-1:0] sat_add(logic [CW-1:0] s, logic [PRD_W-1:0] p);
		logic [SUM_W-1:0] sum;
		logic [SH_W-1:0] sh;
		logic [CW-1:0] res;
		sh  = p[PRD_W-1:FRAC_BITS];
		sum = {{(SUM_W-CW){s[CW-1]}}, s} + {sh[SH_W-1], sh};
		if (sum[SUM_W-1:CW-1] == '0 || sum[SUM_W-1:CW-1] == '1) begin
			res = sum[CW-1:0];
		end else begin
			res = {sum[SUM_W-1], {(CW-1){!sum[SUM_W-1]}}};
		end
		return res;
	endfunction

	always_comb begin
		if (d_in.zero || !d_in.positive) begin
			t_c = '0;
		end else if (d_in.ovf) begin
			t_c = T_MAX;
		end else begin
			t_c = d_in.q;
		end
		if (d_in.seg && t_c > T_ONE) begin
			t_c = T_ONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= t_c;
			sx_s1   <= d_in.sx;
			sy_s1   <= d_in.sy;
			dx_s1   <= d_in.dx;
			dy_s1   <= d_in.dy;
			zero_s1 <= d_in.zero;
			seg_s1  <= d_in.seg;

			px_s2   <= $signed(dx_s1) * $signed({1'b0, t_s1});
			py_s2   <= $signed(dy_s1) * $signed({1'b0, t_s1});
			sx_s2   <= sx_s1;
			sy_s2   <= sy_s1;
			t_s2    <= t_s1;
			zero_s2 <= zero_s1;

			nx_s3   <= sat_add(sx_s2, px_s2);
			ny_s3   <= sat_add(sy_s2, py_s2);
			t_s3    <= t_s2;
			zero_s3 <= zero_s2;
		end
	end

	assign v_out          = v_s3;
	assign near_x         = IO_W'($signed(nx_s3));
	assign near_y         = IO_W'($signed(ny_s3));
	assign param_t        = t_s3;
	assign zero_direction = zero_s3;

	a_seg_limit: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && seg_s1 |-> t_s1 <= T_ONE)
		else $error("segment t above one");
	a_zero_t: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && zero_s1 |-> t_s1 == '0)
		else $error("zero direction with nonzero t");
	a_t_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en && v_s2 |=> v_s2 && $stable(t_s2))
		else $error("stalled stage changed");

endmodule

// ===== rtl/closest_point_on_segment.sv =====
// Closest point on a line segment or ray, signed Q16.16 coordinates.
// Input channel (in_valid/in_ready) carries a query point, a line start and
// a direction; each request yields exactly one result on the output channel
// (out_valid/out_ready): the nearest point, the clamped parameter t and a
// flag for a zero-length direction, in which case the start is returned.
// Configuration channel (cfg_valid/cfg_ready, always ready) writes the one
// mode bit: 1 clamps t to 0..1, 0 clamps at zero and T_MAX. Write it only
// while the pipeline is empty; each request samples it on entry.
// Four front stages (difference, products, sums, divider seed), 31 restoring
// divider stages producing one quotient bit each, and three back stages
// (clamp, scale, add and saturate); the divider chain sets the depth.
// Throughput is one request per cycle while no result waits unread.
// Reset clears every valid bit and sets segment mode; the pipeline is then
// empty and ready at once.
// A stalled receiver freezes every stage together: in_ready drops only
// while a result waits unread, and nothing is lost or repeated.
module closest_point_on_segment import cps_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [IO_W-1:0] point_x,
	input  logic [IO_W-1:0] point_y,
	input  logic [IO_W-1:0] start_x,
	input  logic [IO_W-1:0] start_y,
	input  logic [IO_W-1:0] dir_x,
	input  logic [IO_W-1:0] dir_y,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [IO_W-1:0] near_x,
	output logic [IO_W-1:0] near_y,
	output logic [T_W-1:0]  param_t,
	output logic            zero_direction,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_data
);

	logic en;
	logic seg_mode_q;
	logic [DIV_STAGES:0] v_chain;
	div_t d_chain [DIV_STAGES+1];

	// advance the whole pipeline unless a finished result is held back
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_mode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			seg_mode_q <= cfg_data;
		end
	end

	cps_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (in_valid && in_ready),
		.seg_mode (seg_mode_q),
		.point_x  (point_x),
		.point_y  (point_y),
		.start_x  (start_x),
		.start_y  (start_y),
		.dir_x    (dir_x),
		.dir_y    (dir_y),
		.v_out    (v_chain[0]),
		.d_out    (d_chain[0])
	);

	// one quotient bit per stage, most significant first
	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		cps_div_stage u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.v_in   (v_chain[i]),
			.d_in   (d_chain[i]),
			.v_out  (v_chain[i+1]),
			.d_out  (d_chain[i+1])
		);
	end

	cps_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.v_in           (v_chain[DIV_STAGES]),
		.d_in           (d_chain[DIV_STAGES]),
		.v_out          (out_valid),
		.near_x         (near_x),
		.near_y         (near_y),
		.param_t        (param_t),
		.zero_direction (zero_direction)
	);

	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_direction |-> param_t == '0)
		else $error("zero direction result with nonzero t");
	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input held off without a waiting result");
	a_chain_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_chain))
		else $error("divider chain moved during a stall");

endmodule

// ===== tb/sv/tb_closest_point_on_segment.sv =====
module tb_closest_point_on_segment;
	timeunit 1ns;
	timeprecision 1ps;

	import cps_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_PER_PHASE = 250;

	// One predicted answer: the nearest point, the clamped t and the flag.
	typedef struct {
		logic [IO_W-1:0] nx;
		logic [IO_W-1:0] ny;
		logic [T_W-1:0]  t;
		logic            zero;
	} nearest_t;

	// Holds the mode bit and the answers still owed by the block, oldest first.
	class nearest_scoreboard;
		bit       seg_mode = 1'b1;
		nearest_t owed[$];
		int       mismatches;

		// Truncated quotient bits of num/den, num < den.
		function automatic bit [63:0] fraction_bits(bit [63:0] num, bit [63:0] den);
			bit [63:0] q;
			q = 0;
			for (int i = 0; i < FRAC_BITS; i++) begin
				num = num << 1;
				q   = q << 1;
				if (num >= den) begin
					num  = num - den;
					q[0] = 1'b1;
				end
			end
			return q;
		endfunction

		function automatic bit [IO_W-1:0] clip(longint v);
			if (v > longint'(32'h7fff_ffff))
				return 32'h7fff_ffff;
			if (v < -longint'(64'h8000_0000))
				return 32'h8000_0000;
			return v[IO_W-1:0];
		endfunction

		function automatic nearest_t project(bit [31:0] px, bit [31:0] py, bit [31:0] sx,
				bit [31:0] sy, bit [31:0] dx, bit [31:0] dy);
			longint    vx, vy, p1, p2, ddx, ddy, ssx, ssy;
			bit [63:0] len2, dot, q, r, t;
			bit        positive;
			nearest_t  res;
			ssx  = longint'(signed'(sx));
			ssy  = longint'(signed'(sy));
			ddx  = longint'(signed'(dx));
			ddy  = longint'(signed'(dy));
			vx   = longint'(signed'(px)) - ssx;
			vy   = longint'(signed'(py)) - ssy;
			p1   = vx * ddx;
			p2   = vy * ddy;
			len2 = 64'(ddx * ddx) + 64'(ddy * ddy);
			dot  = 64'(p1) + 64'(p2);
			t    = 0;
			if (len2 == 0) begin
				res.nx   = clip(ssx);
				res.ny   = clip(ssy);
				res.t    = '0;
				res.zero = 1'b1;
				return res;
			end
			if (p1 >= 0 && p2 >= 0)
				positive = dot != 0;
			else if (p1 < 0 && p2 < 0)
				positive = 1'b0;
			else
				positive = !dot[63] && dot != 0;
			if (positive) begin
				if (seg_mode) begin
					t = (dot >= len2) ? (64'd1 << FRAC_BITS) : fraction_bits(dot, len2);
				end else begin
					q = dot / len2;
					r = dot % len2;
					if (q > (64'h7fff_ffff >> FRAC_BITS)) begin
						t = 64'h7fff_ffff;
					end else begin
						t = (q << FRAC_BITS) | fraction_bits(r, len2);
						if (t > 64'h7fff_ffff)
							t = 64'h7fff_ffff;
					end
				end
			end
			res.nx   = clip(ssx + ((ddx * longint'(t)) >>> FRAC_BITS));
			res.ny   = clip(ssy + ((ddy * longint'(t)) >>> FRAC_BITS));
			res.t    = t[T_W-1:0];
			res.zero = 1'b0;
			return res;
		endfunction

		function void note_request(bit [31:0] px, bit [31:0] py, bit [31:0] sx,
				bit [31:0] sy, bit [31:0] dx, bit [31:0] dy);
			owed.push_back(project(px, py, sx, sy, dx, dy));
		endfunction

		function void check_result(logic [IO_W-1:0] nx, logic [IO_W-1:0] ny,
				logic [T_W-1:0] t, logic zero);
			nearest_t e;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result near=(%h,%h) t=%h zero=%b", nx, ny, t, zero);
				return;
			end
			e = owed.pop_front();
			if (nx !== e.nx || ny !== e.ny || t !== e.t || zero !== e.zero) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected near=(%h,%h) t=%h zero=%b, got (%h,%h) t=%h zero=%b",
						e.nx, e.ny, e.t, e.zero, nx, ny, t, zero);
			end
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	logic [IO_W-1:0] point_x, point_y, start_x, start_y, dir_x, dir_y;
	logic            out_valid;
	logic            out_ready;
	logic [IO_W-1:0] near_x, near_y;
	logic [T_W-1:0]  param_t;
	logic            zero_direction;
	logic            cfg_valid;
	logic            cfg_ready;
	logic            cfg_data;

	nearest_scoreboard sb = new();

	int send_idle_pct;
	int recv_stall_pct;
	logic hold_off;
	int quiet_cycles;

	closest_point_on_segment dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.point_x        (point_x),
		.point_y        (point_y),
		.start_x        (start_x),
		.start_y        (start_y),
		.dir_x          (dir_x),
		.dir_y          (dir_y),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.near_x         (near_x),
		.near_y         (near_y),
		.param_t        (param_t),
		.zero_direction (zero_direction),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver: stall at the phase's rate, or hold off entirely while asked.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if (hold_off)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Check every result taken by the receiver against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(near_x, near_y, param_t, zero_direction);
	end

	// Watchdog: count cycles with no handshake on any channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Offer one request, idling first at the phase's rate; note it once taken.
	task automatic send_request(bit [31:0] px, bit [31:0] py, bit [31:0] sx,
			bit [31:0] sy, bit [31:0] dx, bit [31:0] dy);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		point_x  <= px;
		point_y  <= py;
		start_x  <= sx;
		start_y  <= sy;
		dir_x    <= dx;
		dir_y    <= dy;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(px, py, sx, sy, dx, dy);
	endtask

	// Drop valid and wait until every owed result is back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(bit mode);
		drain();
		cfg_data  <= mode;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.seg_mode = mode;
		cfg_valid <= 1'b0;
	endtask

	// Coordinate near the origin, from -16.0 to +16.0, in Q16.16.
	function automatic bit [31:0] near_coord();
		return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
	endfunction

	task automatic send_directed();
		// zero direction, including extreme start
		send_request(32'h0001_0000, 32'h0002_0000, 32'h8000_0000, 32'h7fff_ffff, 0, 0);
		send_request(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, 0);
		// point behind the start, and at a right angle
		send_request(32'hfffe_0000, 0, 0, 0, 32'h0001_0000, 0);
		send_request(0, 32'h0005_0000, 0, 0, 32'h0001_0000, 0);
		// inside the segment, at its end, beyond its end
		send_request(32'h0000_8000, 32'h0001_0000, 0, 0, 32'h0001_0000, 0);
		send_request(32'h0003_0000, 32'h0004_0000, 0, 0, 32'h0003_0000, 32'h0004_0000);
		send_request(32'h0030_0000, 32'h0001_0000, 0, 0, 32'h0001_0000, 32'h0000_1000);
		// recurring fraction, truncated
		send_request(32'h0001_0000, 0, 0, 0, 32'h0003_0000, 0);
		// negative direction: floor of D*t
		send_request(32'hffff_0000, 32'hffff_8000, 0, 0, 32'hfffd_0000, 32'hffff_0001);
		// huge t along a tiny direction
		send_request(32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 32'h0000_0001, 32'h0000_0001);
		send_request(32'h7fff_ffff, 0, 32'h8000_0000, 0, 32'h0000_0003, 0);
		// all fields at the extremes, then every field at -1 LSB
		send_request(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff);
		send_request(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000);
		send_request(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000, 32'h7fff_ffff);
		send_request(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff);
		// output just below the top of the range
		send_request(32'h7fff_ffff, 0, 32'h7000_0000, 0, 32'h7fff_ffff, 0);
	endtask

	task automatic send_random(int count);
		int kind;
		bit [31:0] px, py, sx, sy, dx, dy;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 99);
			px = near_coord(); py = near_coord();
			sx = near_coord(); sy = near_coord();
			dx = near_coord(); dy = near_coord();
			if (kind < 20) begin
				px = $urandom; py = $urandom; sx = $urandom;
				sy = $urandom; dx = $urandom; dy = $urandom;
			end else if (kind < 27) begin
				dx = 0; dy = 0;
			end else if (kind < 37) begin
				// tiny direction, far point: large t in ray mode
				dx = 32'($urandom_range(0, 64)) - 32;
				dy = 32'($urandom_range(0, 64)) - 32;
				px = $urandom; py = $urandom;
			end else if (kind < 45) begin
				// start near the edge of the range so the point may saturate
				sx = $urandom_range(0, 1) ? 32'h7ff0_0000 + near_coord()
					: 32'h8010_0000 + near_coord();
				dx = $urandom; px = $urandom;
			end
			send_request(px, py, sx, sy, dx, dy);
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		point_x        <= '0;
		point_y        <= '0;
		start_x        <= '0;
		start_y        <= '0;
		dir_x          <= '0;
		dir_y          <= '0;
		cfg_valid      <= 1'b0;
		cfg_data       <= 1'b0;
		hold_off       <= 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Segment mode from reset, no idling; then back-pressure: hold the
		// receiver off while requests keep coming so the pipeline fills.
		send_directed();
		fork
			begin
				hold_off <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off <= 1'b0;
			end
		join_none
		send_random(RANDOM_PER_PHASE);
		// Pause the sender until every result is back.
		drain();

		write_mode(1'b0);
		send_idle_pct = 47;
		send_directed();
		send_random(RANDOM_PER_PHASE);

		write_mode(1'b1);
		send_idle_pct  = 0;
		recv_stall_pct = 47;
		send_random(RANDOM_PER_PHASE);

		write_mode(1'b0);
		send_idle_pct  = 12;
		recv_stall_pct = 12;
		send_random(RANDOM_PER_PHASE);

		drain();
		if (sb.mismatches == 0 && sb.owed.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
